FILE: rtl/slt_pkg.sv
`default_nettype none

package slt_pkg;

  // Widths of the result fields.
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned START_W = 12;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned ERR_W   = 3;

  // Depth of the queue between the lexer and the result formatter.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic KIND_TOKEN   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] CHAR_LT   = 8'h3C;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_PIPE = 8'h7C;

  typedef enum logic [TYPE_W-1:0] {
    TOK_STRING  = 3'd0,
    TOK_READ    = 3'd1,
    TOK_WRITE   = 3'd2,
    TOK_PIPE    = 3'd3,
    TOK_HEREDOC = 3'd4,
    TOK_APPEND  = 3'd5
  } tok_type_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE          = 3'd0,
    ERR_LEADING_PIPE  = 3'd1,
    ERR_TRAILING_OP   = 3'd2,
    ERR_REDIR_NO_WORD = 3'd3,
    ERR_DOUBLE_PIPE   = 3'd4
  } err_e;

  // One lexer event: an optional finished token and an optional line verdict.
  typedef struct packed {
    logic               tok_vld;
    tok_type_e          tok_type;
    logic [START_W-1:0] tok_start;
    logic [LEN_W-1:0]   tok_len;
    logic [SEG_W-1:0]   tok_seg;
    logic               eol;
    err_e               err;
  } lex_evt_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h24) || (b == 8'h09) || (b == 8'h0B) ||
           (b == 8'h0D) || (b == 8'h0A) || (b == 8'h0C);
  endfunction

  function automatic tok_type_e classify(input logic [7:0] f, input logic [7:0] s);
    tok_type_e t;
    t = TOK_STRING;
    if (f == CHAR_LT) begin
      t = (s == CHAR_LT) ? TOK_HEREDOC : TOK_READ;
    end else if (f == CHAR_GT) begin
      t = (s == CHAR_GT) ? TOK_APPEND : TOK_WRITE;
    end else if (f == CHAR_PIPE) begin
      t = TOK_PIPE;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/slt_front.sv
`default_nettype none

module slt_front import slt_pkg::*; #(
  parameter int unsigned LINE_BYTES  = 4096,
  parameter int unsigned SEGMENT_MAX = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] line_byte_i,
  input  wire logic       end_of_line_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output lex_evt_t        evt_o
);

  localparam int unsigned PW = $clog2(LINE_BYTES);
  localparam int unsigned LW = $clog2(LINE_BYTES + 1);
  localparam int unsigned CW = $clog2(SEGMENT_MAX + 1);

  logic          inside_q, inside_d;
  logic [PW-1:0] start_q, start_d;
  logic [LW-1:0] len_q, len_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    second_q, second_d;
  logic [PW-1:0] pos_q, pos_d;
  tok_type_e     prev_q, prev_d;
  logic          seen_q, seen_d;
  logic [CW-1:0] pipe_q, pipe_d;
  err_e          pend_q, pend_d;

  logic          accept;
  logic          delim;
  logic          tok_fin;
  logic          redir;
  tok_type_e     tok_t;
  err_e          verdict;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign delim      = is_delim(line_byte_i);
  // A token closes on a delimiter after token bytes, or on a token byte at line end.
  assign tok_fin    = (delim && inside_q) || (end_of_line_i && !delim);

  always_comb begin
    start_d  = start_q;
    len_d    = len_q;
    first_d  = first_q;
    second_d = second_q;
    inside_d = inside_q;
    if (delim) begin
      inside_d = 1'b0;
    end else if (!inside_q) begin
      inside_d = 1'b1;
      start_d  = pos_q;
      len_d    = LW'(1);
      first_d  = line_byte_i;
      second_d = 8'h00;
    end else begin
      if (len_q == LW'(1)) begin
        second_d = line_byte_i;
      end
      if (len_q < LW'(LINE_BYTES)) begin
        len_d = len_q + LW'(1);
      end
    end

    pos_d = pos_q;
    if (pos_q < PW'(LINE_BYTES - 1)) begin
      pos_d = pos_q + PW'(1);
    end

    tok_t  = classify(first_d, second_d);
    redir  = (prev_q == TOK_READ) || (prev_q == TOK_WRITE) ||
             (prev_q == TOK_HEREDOC) || (prev_q == TOK_APPEND);
    prev_d = prev_q;
    seen_d = seen_q;
    pipe_d = pipe_q;
    pend_d = pend_q;
    if (tok_fin) begin
      inside_d = 1'b0;
      if (!seen_q) begin
        if (tok_t == TOK_PIPE) begin
          pend_d = ERR_LEADING_PIPE;
        end
      end else if (pend_q == ERR_NONE) begin
        if (redir && tok_t != TOK_STRING) begin
          pend_d = ERR_REDIR_NO_WORD;
        end else if (prev_q == TOK_PIPE && tok_t == TOK_PIPE) begin
          pend_d = ERR_DOUBLE_PIPE;
        end
      end
      prev_d = tok_t;
      seen_d = 1'b1;
      if (tok_t == TOK_PIPE && pipe_q < CW'(SEGMENT_MAX)) begin
        pipe_d = pipe_q + CW'(1);
      end
    end

    priority if (!seen_d) begin
      verdict = ERR_NONE;
    end else if (pend_d == ERR_LEADING_PIPE) begin
      verdict = ERR_LEADING_PIPE;
    end else if (prev_d != TOK_STRING) begin
      verdict = ERR_TRAILING_OP;
    end else begin
      verdict = pend_d;
    end
  end

  always_comb begin
    evt_o.tok_vld   = tok_fin;
    evt_o.tok_type  = tok_t;
    evt_o.tok_start = START_W'(start_d);
    evt_o.tok_len   = LEN_W'(len_d);
    evt_o.tok_seg   = SEG_W'(pipe_q);
    evt_o.eol       = end_of_line_i;
    evt_o.err       = verdict;
  end

  assign push_o = accept && (tok_fin || end_of_line_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      start_q  <= '0;
      len_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      pos_q    <= '0;
      prev_q   <= TOK_STRING;
      seen_q   <= 1'b0;
      pipe_q   <= '0;
      pend_q   <= ERR_NONE;
    end else if (accept) begin
      if (end_of_line_i) begin
        // The line is done: start the next one from a clean state.
        inside_q <= 1'b0;
        start_q  <= '0;
        len_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        pos_q    <= '0;
        prev_q   <= TOK_STRING;
        seen_q   <= 1'b0;
        pipe_q   <= '0;
        pend_q   <= ERR_NONE;
      end else begin
        inside_q <= inside_d;
        start_q  <= start_d;
        len_q    <= len_d;
        first_q  <= first_d;
        second_q <= second_d;
        pos_q    <= pos_d;
        prev_q   <= prev_d;
        seen_q   <= seen_d;
        pipe_q   <= pipe_d;
        pend_q   <= pend_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slt_queue.sv
`default_nettype none

module slt_queue import slt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire lex_evt_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output lex_evt_t      head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  lex_evt_t      slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slt_back.sv
`default_nettype none

module slt_back import slt_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire lex_evt_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               result_kind_o,
  output logic [TYPE_W-1:0]  token_type_o,
  output logic [START_W-1:0] token_start_o,
  output logic [LEN_W-1:0]   token_length_o,
  output logic [SEG_W-1:0]   segment_index_o,
  output logic [ERR_W-1:0]   error_code_o,
  output logic               last_of_run_o
);

  // Set once the token half of a token-plus-verdict event has gone out.
  logic phase_q, phase_d;
  logic emit_tok;
  logic accept;

  assign out_valid_o = !empty_i;
  assign emit_tok    = head_i.tok_vld && !phase_q;
  assign accept      = out_valid_o && out_ready_i;
  assign pop_o       = accept && last_of_run_o;

  always_comb begin
    if (emit_tok) begin
      result_kind_o   = KIND_TOKEN;
      token_type_o    = head_i.tok_type;
      token_start_o   = head_i.tok_start;
      token_length_o  = head_i.tok_len;
      segment_index_o = head_i.tok_seg;
      error_code_o    = ERR_NONE;
      last_of_run_o   = !head_i.eol;
    end else begin
      result_kind_o   = KIND_VERDICT;
      token_type_o    = TOK_STRING;
      token_start_o   = '0;
      token_length_o  = '0;
      segment_index_o = '0;
      error_code_o    = head_i.err;
      last_of_run_o   = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      phase_d = 1'b0;
    end else if (accept) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/shell_token_lexer_checker.sv
// Shell command-line lexer and syntax checker.
// Input channel: one request per byte of a command line (line_byte_i), with
// end_of_line_i set on the line's final byte. Output channel: one request per
// result. A token report (result_kind 0) gives the type, start offset, length
// and pipe segment of each token when it closes; a line verdict (result_kind 1)
// follows the final byte and carries the error code. last_of_run_o marks the
// final result caused by one input byte, so a byte yields zero, one or two.
// Throughput is one byte per cycle while the queue has room: the lexer updates
// its small state registers once per accepted byte. Each result is registered
// in the queue before it reaches the output; a byte that closes a token at end
// of line yields two results, sent in turn by the formatter's single output port.
// A two-entry queue separates the lexer from the formatter, so input keeps
// flowing while a result waits; when the receiver stalls and the queue fills,
// in_ready_o drops until an entry drains. Bytes that produce no result take no
// queue space. Reset empties the queue and returns the lexer to the start of a
// line; after each verdict the lexer restarts the same way for the next line.
`default_nettype none

module shell_token_lexer_checker import slt_pkg::*; #(
  parameter int unsigned LINE_BYTES  = 4096,
  parameter int unsigned SEGMENT_MAX = 255
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    line_byte_i,
  input  wire logic          end_of_line_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               result_kind_o,
  output logic [TYPE_W-1:0]  token_type_o,
  output logic [START_W-1:0] token_start_o,
  output logic [LEN_W-1:0]   token_length_o,
  output logic [SEG_W-1:0]   segment_index_o,
  output logic [ERR_W-1:0]   error_code_o,
  output logic               last_of_run_o
);

  // Events travel from the lexer to the formatter through the queue.
  lex_evt_t push_evt;
  lex_evt_t head_evt;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  // The front end tracks token boundaries, classifies each token from its
  // first two bytes and keeps the pending line error.
  slt_front #(
    .LINE_BYTES  (LINE_BYTES),
    .SEGMENT_MAX (SEGMENT_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .evt_o         (push_evt)
  );

  slt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_evt),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_evt)
  );

  // The back end splits each event into its token report and line verdict.
  slt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .head_i          (head_evt),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .token_type_o    (token_type_o),
    .token_start_o   (token_start_o),
    .token_length_o  (token_length_o),
    .segment_index_o (segment_index_o),
    .error_code_o    (error_code_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: test/lexer_result_checker.sv
module lexer_result_checker import slt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [7:0]         line_byte_i,
  input  wire logic               end_of_line_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic               result_kind_i,
  input  wire logic [TYPE_W-1:0]  token_type_i,
  input  wire logic [START_W-1:0] token_start_i,
  input  wire logic [LEN_W-1:0]   token_length_i,
  input  wire logic [SEG_W-1:0]   segment_index_i,
  input  wire logic [ERR_W-1:0]   error_code_i,
  input  wire logic               last_of_run_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             results_owed_o
);

  localparam int unsigned LINE_BYTES   = 4096;
  localparam int unsigned SEGMENT_MAX  = 255;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic               kind;
    logic [TYPE_W-1:0]  tok_type;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [SEG_W-1:0]   segment;
    logic [ERR_W-1:0]   err;
    logic               last;
  } lex_result_t;

  lex_result_t owed_results[$];

  // Our own copy of the lexer state.
  logic               in_token;
  logic [START_W-1:0] token_origin;
  logic [LEN_W-1:0]   token_span;
  logic [7:0]         lead_byte;
  logic [7:0]         second_byte;
  logic [START_W-1:0] line_offset;
  tok_type_e          prior_type;
  logic               any_token;
  logic [SEG_W-1:0]   pipes_seen;
  err_e               held_error;

  function automatic logic is_separator(input logic [7:0] b);
    case (b)
      8'h20, 8'h24, 8'h09, 8'h0B, 8'h0D, 8'h0A, 8'h0C: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic tok_type_e token_kind(input logic [7:0] lead, input logic [7:0] next);
    case (lead)
      CHAR_LT:   return (next == CHAR_LT) ? TOK_HEREDOC : TOK_READ;
      CHAR_GT:   return (next == CHAR_GT) ? TOK_APPEND : TOK_WRITE;
      CHAR_PIPE: return TOK_PIPE;
      default:   return TOK_STRING;
    endcase
  endfunction

  function automatic string show(input lex_result_t r);
    return $sformatf("kind=%0d type=%0d start=%0d len=%0d seg=%0d err=%0d last=%0d",
                     r.kind, r.tok_type, r.start, r.length, r.segment, r.err, r.last);
  endfunction

  task automatic restart_line();
    in_token     = 1'b0;
    token_origin = '0;
    token_span   = '0;
    lead_byte    = '0;
    second_byte  = '0;
    line_offset  = '0;
    prior_type   = TOK_STRING;
    any_token    = 1'b0;
    pipes_seen   = '0;
    held_error   = ERR_NONE;
  endtask

  // Closes the open token, queues its report and updates the line's error.
  task automatic close_token(input logic is_last);
    tok_type_e   t;
    logic        redirect;
    lex_result_t r;
    t = token_kind(lead_byte, second_byte);
    r = '{kind: KIND_TOKEN, tok_type: t, start: token_origin, length: token_span,
          segment: pipes_seen, err: ERR_NONE, last: is_last};
    owed_results.push_back(r);
    redirect = (prior_type == TOK_READ) || (prior_type == TOK_WRITE) ||
               (prior_type == TOK_HEREDOC) || (prior_type == TOK_APPEND);
    if (!any_token) begin
      if (t == TOK_PIPE) held_error = ERR_LEADING_PIPE;
    end else if (held_error == ERR_NONE) begin
      if (redirect && t != TOK_STRING) begin
        held_error = ERR_REDIR_NO_WORD;
      end else if (prior_type == TOK_PIPE && t == TOK_PIPE) begin
        held_error = ERR_DOUBLE_PIPE;
      end
    end
    prior_type = t;
    any_token  = 1'b1;
    if (t == TOK_PIPE && pipes_seen < SEGMENT_MAX) pipes_seen++;
    in_token = 1'b0;
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic eol);
    err_e        verdict;
    lex_result_t r;
    if (is_separator(b)) begin
      if (in_token) close_token(!eol);
    end else if (!in_token) begin
      in_token     = 1'b1;
      token_origin = line_offset;
      token_span   = 1;
      lead_byte    = b;
      second_byte  = '0;
    end else begin
      if (token_span == 1) second_byte = b;
      if (token_span < LINE_BYTES) token_span++;
    end
    if (line_offset < LINE_BYTES - 1) line_offset++;
    if (eol) begin
      if (in_token) close_token(1'b0);
      if (!any_token) begin
        verdict = ERR_NONE;
      end else if (held_error == ERR_LEADING_PIPE) begin
        verdict = ERR_LEADING_PIPE;
      end else if (prior_type != TOK_STRING) begin
        verdict = ERR_TRAILING_OP;
      end else begin
        verdict = held_error;
      end
      r = '{kind: KIND_VERDICT, tok_type: TOK_STRING, start: '0, length: '0,
            segment: '0, err: verdict, last: 1'b1};
      owed_results.push_back(r);
      restart_line();
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) $display("mismatch: %s", what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lex_result_t got;
    lex_result_t want;
    if (!rst_ni) begin
      restart_line();
      owed_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) lex_byte(line_byte_i, end_of_line_i);
      if (out_valid_i && out_ready_i) begin
        got = {result_kind_i, token_type_i, token_start_i, token_length_i,
               segment_index_i, error_code_i, last_of_run_i};
        if (owed_results.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: %s", show(got)));
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            note_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
          end
        end
      end
    end
    results_owed_o = owed_results.size();
  end

endmodule

FILE: test/tb_shell_token_lexer_checker.sv
module tb_shell_token_lexer_checker;
  import slt_pkg::*;

  // Random part of the run, in bytes, before the one long line of pipes.
  localparam int unsigned RANDOM_BYTES = 200;
  // The receiver holds off once; HOLD_AFTER sets when and HOLD_CYCLES sets how long.
  localparam int unsigned HOLD_AFTER   = 500;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Cycles without any accepted request before the run is declared hung. The
  // longest legal quiet stretch is the hold-off plus one long gap.
  localparam int unsigned IDLE_LIMIT   = 3000;
  // Settling time after the checker owes no more results; this is ample margin.
  localparam int unsigned DRAIN_CYCLES = 20;
  // The long line pushes the pipe count past its saturation point.
  localparam int unsigned PIPE_RUN     = 260;

  localparam logic [7:0] SEPARATORS [7] = '{8'h20, 8'h24, 8'h09, 8'h0B, 8'h0D, 8'h0A, 8'h0C};
  localparam tok_type_e REDIRECTS [4] = '{TOK_READ, TOK_WRITE, TOK_HEREDOC, TOK_APPEND};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         line_byte_i;
  logic               end_of_line_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               result_kind_o;
  logic [TYPE_W-1:0]  token_type_o;
  logic [START_W-1:0] token_start_o;
  logic [LEN_W-1:0]   token_length_o;
  logic [SEG_W-1:0]   segment_index_o;
  logic [ERR_W-1:0]   error_code_o;
  logic               last_of_run_o;

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned idle_cycles;

  // Bytes of the line being built; the last one carries end_of_line.
  logic [7:0] line_bytes[$];
  // While set, the sender offers bytes back to back for the current line.
  bit         sender_calm;

  always #2 clk_i = ~clk_i;

  shell_token_lexer_checker u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .line_byte_i     (line_byte_i),
    .end_of_line_i   (end_of_line_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .token_type_o    (token_type_o),
    .token_start_o   (token_start_o),
    .token_length_o  (token_length_o),
    .segment_index_o (segment_index_o),
    .error_code_o    (error_code_o),
    .last_of_run_o   (last_of_run_o)
  );

  // The checker sits beside the block, watches both channels, predicts every
  // result and compares. It hands back a mismatch count and the number of
  // results it still waits for.
  lexer_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .line_byte_i      (line_byte_i),
    .end_of_line_i    (end_of_line_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_i    (result_kind_o),
    .token_type_i     (token_type_o),
    .token_start_i    (token_start_o),
    .token_length_i   (token_length_o),
    .segment_index_i  (segment_index_o),
    .error_code_i     (error_code_o),
    .last_of_run_i    (last_of_run_o),
    .mismatch_count_o (mismatches),
    .results_owed_o   (results_owed)
  );

  // Idle length for either side: mostly none, often a few cycles, and now and
  // then a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A byte that keeps a token going. The first byte of a plain word must not
  // look like an operator, or the word would turn into one.
  function automatic logic [7:0] word_byte(input bit opening);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_delim(b) ||
               (opening && (b == CHAR_LT || b == CHAR_GT || b == CHAR_PIPE)));
    return b;
  endfunction

  task automatic push_separators();
    repeat ($urandom_range(1, 2)) line_bytes.push_back(SEPARATORS[$urandom_range(0, 6)]);
  endtask

  task automatic push_word();
    if (line_bytes.size() > 0) push_separators();
    line_bytes.push_back(word_byte(1'b1));
    repeat ($urandom_range(0, 5)) line_bytes.push_back(word_byte(1'b0));
  endtask

  // Operator tokens; now and then a stray byte is glued on, which gives
  // tokens such as "<<<" or ">f" that still classify by their first two bytes.
  task automatic push_operator(input tok_type_e kind);
    if (line_bytes.size() > 0) push_separators();
    case (kind)
      TOK_READ:    line_bytes.push_back(CHAR_LT);
      TOK_HEREDOC: begin
        line_bytes.push_back(CHAR_LT);
        line_bytes.push_back(CHAR_LT);
      end
      TOK_WRITE:   line_bytes.push_back(CHAR_GT);
      TOK_APPEND:  begin
        line_bytes.push_back(CHAR_GT);
        line_bytes.push_back(CHAR_GT);
      end
      default:     line_bytes.push_back(CHAR_PIPE);
    endcase
    if ($urandom_range(0, 6) == 0) line_bytes.push_back(word_byte(1'b0));
  endtask

  // Most lines are well-formed pipelines of commands with arguments and
  // redirects, which is what gets the checker past its early states. The rest
  // are operators and words in random order, or raw noise.
  task automatic build_random_line();
    int unsigned mode;
    int unsigned segments;
    line_bytes.delete();
    mode = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) push_separators();
    if (mode < 7) begin
      segments = $urandom_range(1, 3);
      for (int unsigned s = 0; s < segments; s++) begin
        if (s > 0) push_operator(TOK_PIPE);
        push_word();
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) begin
            push_operator(REDIRECTS[$urandom_range(0, 3)]);
          end
          push_word();
        end
      end
    end else if (mode < 9) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 1) == 0) begin
          push_word();
        end else begin
          push_operator(tok_type_e'($urandom_range(1, 5)));
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // Trailing delimiters, and the line with no token at all.
    if (line_bytes.size() == 0 || $urandom_range(0, 3) == 0) push_separators();
  endtask

  // Offers one request and returns at the edge that accepts it. Valid is only
  // lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_byte(input logic [7:0] b, input logic eol);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    line_byte_i   <= b;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_line();
    sender_calm = ($urandom_range(0, 5) == 0);
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  initial begin : stimulus
    int unsigned sent;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    line_byte_i   = '0;
    end_of_line_i = 1'b0;
    sender_calm   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A line that is a lone pipe: leading pipe error.
    line_bytes = {CHAR_PIPE};
    send_line();
    // Heredoc then append, ending on an operator: the trailing operator error
    // outranks the redirect followed by an operator.
    line_bytes = {CHAR_LT, CHAR_LT, 8'h20, CHAR_GT, CHAR_GT};
    send_line();
    // Nothing but a delimiter: valid, no token report.
    line_bytes = {8'h24};
    send_line();
    // Two pipes in a row, with the top and bottom byte values as words.
    line_bytes = {8'hFF, 8'h09, CHAR_PIPE, 8'h0B, CHAR_PIPE, 8'h0D, 8'h00};
    send_line();
    // A write whose target is a read: redirect without a word.
    line_bytes = {CHAR_GT, 8'h0A, CHAR_LT, 8'h0C, 8'h78};
    send_line();
    // A read with its word, and the line closed on a delimiter.
    line_bytes = {CHAR_LT, 8'h20, 8'h66, 8'h20};
    send_line();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_random_line();
      send_line();
      sent += line_bytes.size();
    end

    // One long line of pipes, enough of them to saturate the segment index,
    // closed by a word.
    line_bytes.delete();
    repeat (PIPE_RUN) begin
      line_bytes.push_back(CHAR_PIPE);
      line_bytes.push_back(8'h20);
    end
    push_word();
    send_line();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The receiver stalls at random, with stretches of steady readiness, and
  // once holds off long enough for the block's queue to fill and its input to
  // stall while the sender keeps offering bytes.
  initial begin : receiver
    int unsigned stall;
    int unsigned cycles;
    bit          held;
    out_ready_i = 1'b0;
    cycles      = 0;
    held        = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && cycles >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if ($urandom_range(0, 19) == 0) begin
        out_ready_i <= 1'b1;
        stall = $urandom_range(40, 80);
        repeat (stall) @(posedge clk_i);
        cycles += stall;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
          cycles += stall;
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      cycles++;
    end
  end

  // Counts cycles in which neither channel moves a request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/slt_pkg.sv
rtl/slt_front.sv
rtl/slt_queue.sv
rtl/slt_back.sv
rtl/shell_token_lexer_checker.sv
test/lexer_result_checker.sv
test/tb_shell_token_lexer_checker.sv
